>>> design/trd_pkg.sv
// shared types and constants for the targa rle pixel decoder
package trd_pkg;

	localparam logic KIND_START = 1'b0;
	localparam logic KIND_DATA  = 1'b1;

	localparam logic [1:0] CFG_PIXEL_BYTES = 2'd0;
	localparam logic [1:0] CFG_PIXEL_TOTAL = 2'd1;

	localparam logic [2:0]  PIXEL_BYTES_RESET = 3'd3;
	localparam logic [29:0] PIXEL_TOTAL_RESET = 30'd1;

	localparam logic [7:0] RUN_FLAG   = 8'h80;
	localparam logic [6:0] COUNT_MASK = 7'd127;

	typedef struct packed {
		logic       kind;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [31:0] pixel_value;
		logic [1:0]  copies;
		logic        last;
		logic        image_done;
		logic        overrun;
	} out_item_t;

	// one decoded pixel and how many output pixels it stands for;
	// a count of zero marks the "no room left" result
	typedef struct packed {
		logic [31:0] pixel;
		logic [7:0]  count;
		logic        done;
		logic        ovr;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

>>> design/trd_front.sv
// front end: packet parsing, pixel assembly and pixel accounting
module trd_front import trd_pkg::*; #(
	parameter int MAX_PIXEL_BYTES = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        beat,
	input  in_item_t    item,
	input  logic [2:0]  pixel_bytes,
	input  logic [29:0] pixel_total,
	output logic        push,
	output job_t        job
);

	logic        in_packet_q;
	logic        is_run_q;
	logic [7:0]  left_q;
	logic [1:0]  pos_q;
	logic [23:0] asm_q;
	logic [29:0] done_cnt_q;
	logic        finished_q;

	logic [2:0]  pb;
	logic [31:0] full;
	logic [31:0] pix;
	logic        more_bytes;
	logic [29:0] remaining;
	logic [7:0]  left_dec;
	logic [7:0]  run_n;
	logic        run_ovr;
	logic [7:0]  run_cnt;
	logic        is_data;

	always_comb begin
		pb = pixel_bytes;
		if (pb == 3'd0) begin
			pb = 3'd1;
		end else if (pb > 3'(MAX_PIXEL_BYTES)) begin
			pb = 3'(MAX_PIXEL_BYTES);
		end
		full = {8'd0, asm_q} | ({24'd0, item.data_byte} << {pos_q, 3'b000});
		more_bytes = ({1'b0, pos_q} + 3'd1) < pb;
		pix = full;
		if (pb >= 3'd3) begin
			pix = {full[31:24], full[7:0], full[15:8], full[23:16]};
		end
		remaining = (done_cnt_q < pixel_total) ? (pixel_total - done_cnt_q) : 30'd0;
		left_dec = (left_q != 8'd0) ? (left_q - 8'd1) : 8'd0;
		run_n = (left_q == 8'd0) ? 8'd1 : left_q;
		run_ovr = {22'd0, run_n} > remaining;
		run_cnt = run_ovr ? remaining[7:0] : run_n;
		is_data = beat && item.kind == KIND_DATA && !finished_q && in_packet_q && !more_bytes;
	end

	// a completed pixel always yields one job
	always_comb begin
		push = is_data;
		job = '0;
		if (remaining == 30'd0) begin
			job.count = 8'd0;
			job.done = 1'b1;
			job.ovr = 1'b1;
		end else if (!is_run_q) begin
			job.pixel = pix;
			job.count = 8'd1;
			job.done = remaining == 30'd1;
			job.ovr = remaining == 30'd1 && left_dec != 8'd0;
		end else begin
			job.pixel = pix;
			job.count = run_cnt;
			job.done = {22'd0, run_cnt} == remaining;
			job.ovr = run_ovr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_packet_q <= 1'b0;
			is_run_q <= 1'b0;
			left_q <= 8'd0;
			pos_q <= 2'd0;
			asm_q <= 24'd0;
			done_cnt_q <= 30'd0;
			finished_q <= 1'b0;
		end else if (beat) begin
			if (item.kind == KIND_START) begin
				in_packet_q <= 1'b0;
				is_run_q <= 1'b0;
				left_q <= 8'd0;
				pos_q <= 2'd0;
				asm_q <= 24'd0;
				done_cnt_q <= 30'd0;
				finished_q <= 1'b0;
			end else if (!finished_q) begin
				if (!in_packet_q) begin
					is_run_q <= (item.data_byte & RUN_FLAG) != 8'd0;
					left_q <= {1'b0, item.data_byte[6:0] & COUNT_MASK} + 8'd1;
					in_packet_q <= 1'b1;
					pos_q <= 2'd0;
					asm_q <= 24'd0;
				end else if (more_bytes) begin
					asm_q <= full[23:0];
					pos_q <= pos_q + 2'd1;
				end else begin
					pos_q <= 2'd0;
					asm_q <= 24'd0;
					if (remaining == 30'd0) begin
						finished_q <= 1'b1;
						in_packet_q <= 1'b0;
					end else if (!is_run_q) begin
						done_cnt_q <= done_cnt_q + 30'd1;
						left_q <= left_dec;
						if (left_dec == 8'd0 || remaining == 30'd1) begin
							in_packet_q <= 1'b0;
						end
						if (remaining == 30'd1) begin
							finished_q <= 1'b1;
						end
					end else begin
						done_cnt_q <= done_cnt_q + {22'd0, run_cnt};
						left_q <= 8'd0;
						in_packet_q <= 1'b0;
						if ({22'd0, run_cnt} == remaining) begin
							finished_q <= 1'b1;
						end
					end
				end
			end
		end
	end

endmodule

>>> design/trd_queue.sv
// small job queue between the front end and the expander
module trd_queue import trd_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  job_t      push_job,
	input  logic      pop,
	output job_t      head,
	output q_status_t status
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	job_t          mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign status.full  = count_q == CW'(DEPTH);
	assign status.empty = count_q == '0;
	assign do_push = push && !status.full;
	assign do_pop  = pop && !status.empty;
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

>>> design/trd_back.sv
// back end: expands a job into result beats of up to two copies (zero for a no-room job)
module trd_back import trd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  q_status_t q_status,
	input  job_t      head,
	output logic      pop,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item
);

	logic        busy_q;
	logic [31:0] pix_q;
	logic [7:0]  left_q;
	logic        done_q;
	logic        ovr_q;
	logic        out_valid_q;
	out_item_t   out_item_q;

	logic        adv;
	logic [1:0]  cp;
	logic [7:0]  left_next;
	logic        last;

	assign pop = !busy_q && !q_status.empty;
	assign adv = busy_q && (!out_valid_q || out_ready);

	always_comb begin
		if (left_q == 8'd0) begin
			cp = 2'd0;
		end else if (left_q >= 8'd2) begin
			cp = 2'd2;
		end else begin
			cp = 2'd1;
		end
		left_next = left_q - {6'd0, cp};
		last = left_next == 8'd0;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			pix_q <= head.pixel;
			done_q <= head.done;
			ovr_q <= head.ovr;
		end
		if (adv) begin
			out_item_q.pixel_value <= pix_q;
			out_item_q.copies <= cp;
			out_item_q.last <= last;
			out_item_q.image_done <= last && done_q;
			out_item_q.overrun <= last && ovr_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			left_q <= 8'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				left_q <= head.count;
			end else if (adv) begin
				left_q <= left_next;
				if (last) begin
					busy_q <= 1'b0;
				end
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_item = out_item_q;

endmodule

>>> design/tga_rle_pixel_decoder.sv
// top level of the targa rle pixel decoder: config registers, front, queue, back
//
// channel   direction  signals
// in        sink       in_valid, in_ready, in_item (kind, data_byte)
// out       source     out_valid, out_ready, out_item (pixel, copies, flags)
// cfg       sink       cfg_valid, cfg_ready, cfg_index, cfg_data
//
// packet and data bytes are taken one per cycle while the job queue has room.
// a completed pixel becomes one job; the back end loads it from the queue and then
// expands it into result beats of at most two copies each, stalling on out_ready.
// input stalls only when QUEUE_DEPTH jobs wait behind the back end.
// reset clears all control state; config resets to 3 bytes per pixel, total 1.
module tga_rle_pixel_decoder import trd_pkg::*; #(
	parameter int MAX_PIXEL_BYTES = 4,
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_item_t    in_item,
	output logic        out_valid,
	input  logic        out_ready,
	output out_item_t   out_item,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [29:0] cfg_data
);

	logic [2:0]  pixel_bytes_q;
	logic [29:0] pixel_total_q;
	logic        in_beat;
	logic        push;
	job_t        push_job;
	logic        pop;
	job_t        head;
	q_status_t   q_status;

	assign cfg_ready = 1'b1;
	assign in_ready = !q_status.full;
	assign in_beat = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_bytes_q <= PIXEL_BYTES_RESET;
			pixel_total_q <= PIXEL_TOTAL_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_PIXEL_BYTES: pixel_bytes_q <= cfg_data[2:0];
				CFG_PIXEL_TOTAL: pixel_total_q <= cfg_data;
				default: ;
			endcase
		end
	end

	trd_front #(
		.MAX_PIXEL_BYTES(MAX_PIXEL_BYTES)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.beat(in_beat),
		.item(in_item),
		.pixel_bytes(pixel_bytes_q),
		.pixel_total(pixel_total_q),
		.push(push),
		.job(push_job)
	);

	trd_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_job(push_job),
		.pop(pop),
		.head(head),
		.status(q_status)
	);

	trd_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_status(q_status),
		.head(head),
		.pop(pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item(out_item)
	);

`ifndef ASSERT_OFF
	// a zero-copy beat only reports the image being out of room
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.copies == 2'd0 |-> out_item.last && out_item.overrun)
		else $error("zero-copy beat without overrun");

	// flags only ride on the final beat of a pixel
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.last |-> !out_item.image_done && !out_item.overrun)
		else $error("flag on a non-final beat");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.overrun |-> out_item.image_done)
		else $error("overrun without image done");

	// the front must never push into a full queue
	assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_status.full)
		else $error("job pushed into full queue");
`endif

endmodule
